@@ sv/lsbr_pkg.sv @@
`timescale 1ns / 1ps

package lsbr_pkg;

    // default sizes
    localparam int DEF_STORE_BYTES   = 4096;
    localparam int DEF_MAX_READ_BITS = 25;

    // fixed field widths
    localparam int COUNT_W = 8;
    localparam int ADDR_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int SIZE_W  = 16;
    localparam int POS_W   = 16;
    localparam int REM_W   = 17;
    localparam int VALUE_W = 26;

    // four bytes per store word, two words read per lookup
    localparam int WORD_W = 32;
    localparam int WIN_W  = 2 * WORD_W;

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_GET_U   = 3'd1,
        ACT_GET_S   = 3'd2,
        ACT_GET_X   = 3'd3,
        ACT_SHOW    = 3'd4,
        ACT_SKIP    = 3'd5,
        ACT_ALIGN   = 3'd6,
        ACT_RESTART = 3'd7
    } t_action;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } t_wr_req;

endpackage

@@ sv/lsbr_store.sv @@
`timescale 1ns / 1ps

module lsbr_store #(
    parameter int STORE_BYTES = lsbr_pkg::DEF_STORE_BYTES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lsbr_pkg::t_wr_req          i_wr,
    input  logic                       i_rd_en,
    input  logic [lsbr_pkg::POS_W-1:0] i_rd_pos,
    output logic [lsbr_pkg::WIN_W-1:0] o_rd_data,
    output logic                       o_busy
);

    localparam int WORDS = (STORE_BYTES + 3) / 4;
    localparam int RW    = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [lsbr_pkg::WORD_W-1:0] r_mem [WORDS];
    logic [lsbr_pkg::WORD_W-1:0] r_rd_lo;
    logic [lsbr_pkg::WORD_W-1:0] r_rd_hi;
    logic                        r_clr_busy;
    logic [RW-1:0]               r_clr_row;

    logic [16:0]   w_lo_full;
    logic [16:0]   w_hi_full;
    logic [16:0]   w_wr_full;
    logic [RW-1:0] w_row_lo;
    logic [RW-1:0] w_row_hi;
    logic [RW-1:0] w_wr_row;
    logic [1:0]    w_lane;
    logic          w_wr_ok;

    // word holding the first bit and the word after it; rows past the end read row 0,
    // those bits are masked downstream
    assign w_lo_full = 17'(i_rd_pos >> 5);
    assign w_hi_full = w_lo_full + 17'd1;
    assign w_row_lo  = (w_lo_full < 17'(WORDS)) ? w_lo_full[RW-1:0] : '0;
    assign w_row_hi  = (w_hi_full < 17'(WORDS)) ? w_hi_full[RW-1:0] : '0;

    assign w_wr_full = 17'(i_wr.addr >> 2);
    assign w_wr_row  = w_wr_full[RW-1:0];
    assign w_lane    = i_wr.addr[1:0];
    assign w_wr_ok   = i_wr.en && (17'(i_wr.addr) < 17'(STORE_BYTES));

    // zero sweep after reset, one row a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_row  <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_row == RW'(WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_row <= r_clr_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_row] <= '0;
        end else if (w_wr_ok) begin
            r_mem[w_wr_row][{w_lane, 3'b000} +: lsbr_pkg::BYTE_W] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_lo <= r_mem[w_row_lo];
            r_rd_hi <= r_mem[w_row_hi];
        end
    end

    assign o_rd_data = {r_rd_hi, r_rd_lo};
    assign o_busy    = r_clr_busy;

endmodule

@@ sv/lsb_first_bit_reader.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake               payload
// s (item)  in   i_s_tvalid/o_s_tready   tdata: bit_count, byte_address, byte_data
//                                        tuser: action
// m (result)out  o_m_tvalid/i_m_tready   tdata: value, bit_position, bits_remaining
//                                        tuser: bad_count
// cfg       in   i_cfg_we                i_cfg_wdata: stream_size_bits
//
// one item per cycle sustained while the output is not stalled; the store words and the item's
// fields are registered at the transfer edge and the bit extraction then lands in the output
// register, from which the result is taken
// the read position updates at the transfer edge, so the next item can follow at once
// after reset a zero sweep of the store runs with o_s_tready low; config writes are taken
// during the sweep
// a stalled output holds the extraction stage and then the input side

module lsb_first_bit_reader #(
    parameter int STORE_BYTES   = lsbr_pkg::DEF_STORE_BYTES,
    parameter int MAX_READ_BITS = lsbr_pkg::DEF_MAX_READ_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,   // stream_size_bits
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // [7:0] bit_count, [19:8] byte_address,
                                       // [27:20] byte_data, [31:28] zero
    input  logic [2:0]  i_s_tuser,     // [2:0] action
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,     // [25:0] value, [41:26] bit_position,
                                       // [58:42] bits_remaining, [63:59] zero
    output logic [0:0]  o_m_tuser      // [0] bad_count
);

    localparam int STORE_BITS_I = STORE_BYTES * 8;
    // position saturation point
    localparam int CAP_I = (STORE_BITS_I > 65535) ? 65535 : STORE_BITS_I;
    // first bit that reads as zero because it lies past the store
    localparam int LIM_I = (STORE_BITS_I > 65536) ? 65536 : STORE_BITS_I;
    localparam logic [16:0] POS_CAP   = 17'(CAP_I);
    localparam logic [16:0] STORE_LIM = 17'(LIM_I);

    localparam int VW = lsbr_pkg::VALUE_W;
    localparam int PW = lsbr_pkg::POS_W;

    // config register
    logic [lsbr_pkg::SIZE_W-1:0] r_size;

    // read position, updated at each transfer
    logic [PW-1:0] r_pos;
    logic [PW-1:0] n_pos;

    // extraction stage, lines up with the store read data
    logic              r_s1_valid;
    lsbr_pkg::t_action r_s1_action;
    logic [4:0]        r_s1_n;
    logic [4:0]        r_s1_keep;
    logic [4:0]        r_s1_off;
    logic              r_s1_bad;
    logic [PW-1:0]     r_s1_pos;

    // output register
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic        r_out_bad;

    // input side decode
    lsbr_pkg::t_action                w_action;
    logic [lsbr_pkg::COUNT_W-1:0]     w_n;
    logic                             w_accept;
    logic                             w_adv;
    logic                             w_busy;
    logic                             w_is_read;
    logic                             w_bad;
    logic [7:0]                       w_by;
    logic [16:0]                      w_sum;
    logic [16:0]                      w_limit;
    logic [16:0]                      w_avail;
    logic [4:0]                       w_keep;
    lsbr_pkg::t_wr_req                w_wr;
    logic [lsbr_pkg::WIN_W-1:0]       w_rd_data;

    // extraction
    logic [lsbr_pkg::WIN_W-1:0] w_win;
    logic [VW-1:0]              w_keep_mask;
    logic [VW-1:0]              w_n_mask;
    logic [VW-1:0]              w_f;
    logic [VW-1:0]              w_topv;
    logic [VW-1:0]              w_val;
    logic [lsbr_pkg::REM_W-1:0] w_rem;

    assign w_action = lsbr_pkg::t_action'(i_s_tuser);
    assign w_n      = i_s_tdata[7:0];

    // output register frees when empty or being taken
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !w_busy && (!r_s1_valid || w_adv);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // byte loads go straight to the store at their own transfer edge; a later read is
    // issued at a later edge and so always sees the byte
    assign w_wr.en   = w_accept && (w_action == lsbr_pkg::ACT_LOAD);
    assign w_wr.addr = i_s_tdata[19:8];
    assign w_wr.data = i_s_tdata[27:20];

    lsbr_store #(
        .STORE_BYTES (STORE_BYTES)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_wr),
        .i_rd_en   (w_accept),
        .i_rd_pos  (r_pos),
        .o_rd_data (w_rd_data),
        .o_busy    (w_busy)
    );

    always_comb begin
        w_is_read = w_action inside {lsbr_pkg::ACT_GET_U, lsbr_pkg::ACT_GET_S,
                                     lsbr_pkg::ACT_GET_X, lsbr_pkg::ACT_SHOW};
        w_bad     = w_is_read && ((w_n == '0) || (w_n > 8'(MAX_READ_BITS)));

        // how far this item moves the position
        case (w_action)
            lsbr_pkg::ACT_GET_U,
            lsbr_pkg::ACT_GET_S,
            lsbr_pkg::ACT_GET_X: w_by = w_bad ? 8'd0 : w_n;
            lsbr_pkg::ACT_SKIP:  w_by = w_n;
            lsbr_pkg::ACT_ALIGN: w_by = 8'((4'd8 - {1'b0, r_pos[2:0]}) & 4'd7);
            default:             w_by = 8'd0;
        endcase

        w_sum = 17'(r_pos) + 17'(w_by);
        if (w_action == lsbr_pkg::ACT_RESTART) begin
            n_pos = '0;
        end else if (w_sum > POS_CAP) begin
            n_pos = POS_CAP[PW-1:0];
        end else begin
            n_pos = w_sum[PW-1:0];
        end

        // bits that really exist from the current position on
        w_limit = (17'(r_size) < STORE_LIM) ? 17'(r_size) : STORE_LIM;
        w_avail = (w_limit > 17'(r_pos)) ? (w_limit - 17'(r_pos)) : 17'd0;
        w_keep  = (w_avail >= 17'(w_n)) ? w_n[4:0] : w_avail[4:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_pos      <= n_pos;
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_action <= w_action;
            r_s1_n      <= w_n[4:0];
            r_s1_keep   <= w_keep;
            r_s1_off    <= r_pos[4:0];
            r_s1_bad    <= w_bad;
            r_s1_pos    <= n_pos;
        end
    end

    // field extraction from the two store words
    always_comb begin
        w_win = w_rd_data >> r_s1_off;
        for (int i = 0; i < VW; i++) begin
            w_keep_mask[i] = (i < r_s1_keep);
            w_n_mask[i]    = (i < r_s1_n);
        end
        w_f    = w_win[VW-1:0] & w_keep_mask;
        // bit n-1 of the field
        w_topv = w_f >> (r_s1_n - 5'd1);

        case (r_s1_action)
            lsbr_pkg::ACT_GET_U,
            lsbr_pkg::ACT_SHOW:  w_val = w_f;
            lsbr_pkg::ACT_GET_S: w_val = w_topv[0] ? (w_f | ~w_n_mask) : w_f;
            // top bit set keeps the field, clear gives minus its complement
            lsbr_pkg::ACT_GET_X: w_val = w_topv[0] ? w_f : (VW'(0) - (~w_f & w_n_mask));
            default:             w_val = '0;
        endcase
        if (r_s1_bad) begin
            w_val = '0;
        end

        w_rem = 17'(r_size) - 17'(r_s1_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_data <= {5'b00000, w_rem, r_s1_pos, w_val};
            r_out_bad  <= r_s1_bad;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = r_out_data;
    assign o_m_tuser[0] = r_out_bad;

    // a result only shows up after the extraction stage held an item
    a_out_from_s1 : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_s1_valid))
        else $error("result appeared without an item in the extraction stage");

    // the position never passes its saturation point
    a_pos_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (17'(r_pos) <= POS_CAP))
        else $error("read position beyond its limit");

    // a rejected count answers zero
    a_bad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[25:0] == 26'd0))
        else $error("bad count result with nonzero value");

    // restart lands at bit zero
    a_restart : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == lsbr_pkg::ACT_RESTART)) |=> (r_pos == '0))
        else $error("restart did not clear the position");

endmodule
